[rtl/lfu_pkg.sv]
// Shared types and constants for the LFU cache with LRU tie-break.
package lfu_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int USES_W  = 32;
   localparam int STAMP_W = 64;
   localparam int CAP_W   = 5;

   localparam logic ACT_GET = 1'b0;
   localparam logic ACT_PUT = 1'b1;

   localparam logic [CAP_W-1:0]          CAP_RESET  = 5'd16;
   localparam logic signed [VALUE_W-1:0] VALUE_MISS = -32'sd1;
   localparam logic signed [VALUE_W-1:0] VALUE_PUT  = 32'sd0;
   localparam logic [USES_W-1:0]         USES_ONE   = 32'd1;
   localparam logic [USES_W-1:0]         USES_MAX   = 32'hFFFF_FFFF;
   localparam logic [STAMP_W-1:0]        STAMP_ONE  = 64'd1;

   typedef struct packed {
      logic                      action;
      logic signed [KEY_W-1:0]   key;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic signed [VALUE_W-1:0] read_value;
   } rsp_type;

   // One cache slot as held in the slot RAM.
   typedef struct packed {
      logic signed [KEY_W-1:0]   key;
      logic signed [VALUE_W-1:0] value;
      logic [USES_W-1:0]         uses;
      logic [STAMP_W-1:0]        stamp;
   } entry_type;

   // Status of the scan unit after a full pass.
   typedef struct packed {
      logic hit;
      logic free_found;
      logic best_found;
   } scan_flags_type;

endpackage

[rtl/lfu_req_if.sv]
// Request channel: valid/ready handshake with get/put payload.
interface lfu_req_if
   import lfu_pkg::*;
();

   logic                      valid;
   logic                      ready;
   logic                      action;
   logic signed [KEY_W-1:0]   key;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, action, key, value, input ready);
   modport sink   (input valid, action, key, value, output ready);
endinterface

[rtl/lfu_rsp_if.sv]
// Response channel: valid/ready handshake with hit flag and read value.
interface lfu_rsp_if
   import lfu_pkg::*;
();

   logic                      valid;
   logic                      ready;
   logic                      hit;
   logic signed [VALUE_W-1:0] read_value;

   modport source (output valid, hit, read_value, input ready);
   modport sink   (input valid, hit, read_value, output ready);
endinterface

[rtl/lfu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lfu_scan.sv]
// Scan unit: key match, first free slot and eviction minimum, one slot per cycle while chk_en is high.
module lfu_scan
   import lfu_pkg::*;
#(
   parameter int ENTRIES = 16,
   localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                    clock,
   input  logic                    clear,
   input  logic                    chk_en,
   input  logic [IdxW-1:0]         chk_idx,
   input  logic                    chk_valid,
   input  entry_type               chk_entry,
   input  logic signed [KEY_W-1:0] lookup_key,
   output scan_flags_type          flags,
   output logic [IdxW-1:0]         hit_idx,
   output entry_type               hit_entry,
   output logic [IdxW-1:0]         free_idx,
   output logic [IdxW-1:0]         best_idx
);

   scan_flags_type       flags_ff;
   logic [IdxW-1:0]      hit_idx_ff;
   entry_type            hit_entry_ff;
   logic [IdxW-1:0]      free_idx_ff;
   logic [IdxW-1:0]      best_idx_ff;
   logic [USES_W-1:0]    best_uses_ff;
   logic [STAMP_W-1:0]   best_stamp_ff;

   logic key_eq;
   logic older;

   assign key_eq = (chk_entry.key == lookup_key);
   // fewer uses wins; equal uses, earlier stamp wins; full tie keeps lower slot
   assign older  = {chk_entry.uses, chk_entry.stamp} < {best_uses_ff, best_stamp_ff};

   always_ff @(posedge clock) begin
      if (clear) begin
         flags_ff <= '0;
      end else if (chk_en) begin
         if (chk_valid) begin
            if (key_eq && !flags_ff.hit) begin
               flags_ff.hit <= 1'b1;
               hit_idx_ff   <= chk_idx;
               hit_entry_ff <= chk_entry;
            end
            if (!flags_ff.best_found || older) begin
               flags_ff.best_found <= 1'b1;
               best_idx_ff         <= chk_idx;
               best_uses_ff        <= chk_entry.uses;
               best_stamp_ff       <= chk_entry.stamp;
            end
         end else if (!flags_ff.free_found) begin
            flags_ff.free_found <= 1'b1;
            free_idx_ff         <= chk_idx;
         end
      end
   end

   assign flags     = flags_ff;
   assign hit_idx   = hit_idx_ff;
   assign hit_entry = hit_entry_ff;
   assign free_idx  = free_idx_ff;
   assign best_idx  = best_idx_ff;

endmodule

[rtl/lfu_cache_lru_tiebreak.sv]
// Top level of the LFU key/value cache with least-recently-reached tie-break.
// Each request transfer is a get or a put of a 32-bit key; each one yields exactly one
// response transfer {hit, read_value}. Slots live in a single RAM that one scan unit
// walks one slot per cycle, finding the key match, the lowest free slot and the
// eviction victim (fewest uses, then earliest stamp of reaching that count, then
// lowest slot). A request is accepted, then every slot is read through the RAM's
// single read port, then the read pipeline drains and the update step follows.
// A finished response waits in an output register, so the next request is accepted
// and scanned while it is pending; the update step holds until the register frees.
// Capacity (csr_wr_data, resets to 16, clipped to ENTRIES) must be written by the user
// only while idle; the block does not enforce this. Capacity zero turns puts into no-ops
// that still report hit. Use counts saturate; the 64-bit stamp counter wraps. Valid
// bits are flip-flops cleared by reset, so no clearing pass is needed.
module lfu_cache_lru_tiebreak
   import lfu_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data,
   lfu_req_if.sink          req_chan,
   lfu_rsp_if.source        rsp_chan
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic               chk_en_ff;
   logic [IDX_W-1:0]   chk_idx_ff;
   req_type            req_ff;
   logic [CAP_W-1:0]   capacity_ff;
   logic [CNT_W-1:0]   occ_ff;
   logic [STAMP_W-1:0] stamp_ff;
   logic [ENTRIES-1:0] valid_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   // handshakes
   logic req_xfer;
   logic rsp_xfer;
   logic commit;

   // scan results
   scan_flags_type   flags;
   logic [IDX_W-1:0] hit_idx;
   entry_type        hit_entry;
   logic [IDX_W-1:0] free_idx;
   logic [IDX_W-1:0] best_idx;

   // RAM ports
   logic                        rd_en;
   logic [$bits(entry_type)-1:0] rd_data;
   entry_type                   rd_entry;
   logic                        upd_wr;
   logic                        ram_wr_en;
   logic [IDX_W-1:0]            ram_wr_addr;
   entry_type                   ram_wr_data;

   // update decisions
   logic      sat;
   logic      room;
   entry_type bumped;
   logic      stamp_inc;
   logic      set_valid;
   logic      occ_inc;
   rsp_type   rsp_in;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_xfer       = rsp_valid_ff && rsp_chan.ready;
   assign commit         = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_chan.ready);

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rd_en    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            rd_en  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last slot is checked this cycle
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         chk_en_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         chk_en_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= cnt_ff;
      if (req_xfer) begin
         req_ff.action <= req_chan.action;
         req_ff.key    <= req_chan.key;
         req_ff.value  <= req_chan.value;
      end
   end

   // ---------------- slot storage and scan ----------------
   lfu_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (ENTRIES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff),
      .rd_data (rd_data)
   );

   assign rd_entry = entry_type'(rd_data);

   lfu_scan #(
      .ENTRIES (ENTRIES)
   ) u_scan (
      .clock      (clock),
      .clear      (req_xfer),
      .chk_en     (chk_en_ff),
      .chk_idx    (chk_idx_ff),
      .chk_valid  (valid_ff[chk_idx_ff]),
      .chk_entry  (rd_entry),
      .lookup_key (req_ff.key),
      .flags      (flags),
      .hit_idx    (hit_idx),
      .hit_entry  (hit_entry),
      .free_idx   (free_idx),
      .best_idx   (best_idx)
   );

   // ---------------- update step ----------------
   assign sat  = (hit_entry.uses == USES_MAX);
   // free slot allowed while occupancy is below min(capacity, ENTRIES)
   assign room = (CMP_W'(occ_ff) < CMP_W'(capacity_ff)) && (occ_ff < CNT_W'(ENTRIES));

   always_comb begin
      bumped = hit_entry;
      if (!sat) begin
         bumped.uses  = hit_entry.uses + USES_ONE;
         bumped.stamp = stamp_ff;
      end
   end

   always_comb begin
      upd_wr            = 1'b0;
      ram_wr_addr       = hit_idx;
      ram_wr_data       = bumped;
      stamp_inc         = 1'b0;
      set_valid         = 1'b0;
      occ_inc           = 1'b0;
      rsp_in.hit        = flags.hit;
      rsp_in.read_value = VALUE_PUT;
      if (req_ff.action == ACT_GET) begin
         if (flags.hit) begin
            rsp_in.read_value = hit_entry.value;
            upd_wr            = !sat;
            stamp_inc         = !sat;
         end else begin
            rsp_in.read_value = VALUE_MISS;
         end
      end else if (capacity_ff != '0) begin
         if (flags.hit) begin
            // update in place, value replaced even when uses are saturated
            upd_wr            = 1'b1;
            ram_wr_data.value = req_ff.value;
            stamp_inc         = !sat;
         end else begin
            // insert: lowest free slot, else evict the victim
            upd_wr            = 1'b1;
            ram_wr_addr       = room ? free_idx : best_idx;
            ram_wr_data.key   = req_ff.key;
            ram_wr_data.value = req_ff.value;
            ram_wr_data.uses  = USES_ONE;
            ram_wr_data.stamp = stamp_ff;
            stamp_inc         = 1'b1;
            set_valid         = 1'b1;
            occ_inc           = room;
         end
      end
   end

   assign ram_wr_en = commit && upd_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         occ_ff       <= '0;
         stamp_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (commit) begin
            if (stamp_inc) begin
               stamp_ff <= stamp_ff + STAMP_ONE;
            end
            if (set_valid) begin
               valid_ff[ram_wr_addr] <= 1'b1;
            end
            if (occ_inc) begin
               occ_ff <= occ_ff + 1'b1;
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_xfer) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hit        = rsp_ff.hit;
   assign rsp_chan.read_value = rsp_ff.read_value;

   // ---------------- assertions ----------------
   // occupancy tracks the number of valid slots
   a_occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(occ_ff))
      else $error("occupancy differs from valid slot count");

   // slot RAM is written only in the update step with the output register free
   a_write_in_update: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_chan.ready))
      else $error("slot write outside update step");

   // an accepted request starts the scan at slot zero
   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_SCAN) && (cnt_ff == '0))
      else $error("scan did not start after accept");

   // a pending response is never overwritten before it is taken
   a_rsp_not_lost: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !commit)
      else $error("response overwritten while pending");

endmodule

[dv/lfu_cache_lru_tiebreak_tb.sv]
// Self-checking testbench for the LFU cache with least-recently-reached tie-break.
module lfu_cache_lru_tiebreak_tb
   import lfu_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CACHE_SLOTS    = 16;
   localparam int POOL_KEYS      = 24;
   localparam int HOLD_AT_RSP    = 150;   // response count at which the sink stalls
   localparam int HOLD_CYCLES    = 300;   // length of that stall
   localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before the run is declared hung
   localparam int DRAIN_CYCLES   = 40;    // wait after the last response before the verdict

   localparam logic signed [KEY_W-1:0]   KEY_MIN   = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0]   KEY_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [KEY_W-1:0]   KEY_ZERO  = 32'sh0000_0000;
   localparam logic signed [KEY_W-1:0]   KEY_ONES  = 32'shFFFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

   // ------------------------------------------------------------------
   // Cache predictor and expected-response store.
   // Mirrors the slot state: valid bit, key, value, use count and the
   // stamp of when that use count was reached.
   // ------------------------------------------------------------------
   class cache_scoreboard;
      bit                        slot_used  [CACHE_SLOTS];
      logic        [KEY_W-1:0]   slot_key   [CACHE_SLOTS];
      logic signed [VALUE_W-1:0] slot_value [CACHE_SLOTS];
      logic        [USES_W-1:0]  slot_uses  [CACHE_SLOTS];
      logic        [STAMP_W-1:0] slot_stamp [CACHE_SLOTS];
      logic        [STAMP_W-1:0] stamp_count;
      int unsigned               fill_count;
      logic        [CAP_W-1:0]   capacity;
      rsp_type                   expected_rsp [$];
      int                        errors;

      function new();
         for (int i = 0; i < CACHE_SLOTS; i++) begin
            slot_used[i]  = 1'b0;
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_uses[i]  = '0;
            slot_stamp[i] = '0;
         end
         stamp_count = '0;
         fill_count  = 0;
         capacity    = CAP_RESET;
         errors      = 0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] cap);
         capacity = cap;
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      function int find_key(logic [KEY_W-1:0] k);
         for (int i = 0; i < CACHE_SLOTS; i++)
            if (slot_used[i] && slot_key[i] == k)
               return i;
         return -1;
      endfunction

      // Saturated counts keep their stamp.
      function void bump_use(int i);
         if (slot_uses[i] != USES_MAX) begin
            slot_uses[i]  = slot_uses[i] + USES_ONE;
            slot_stamp[i] = stamp_count;
            stamp_count   = stamp_count + STAMP_ONE;
         end
      endfunction

      // Lowest free slot while under capacity, else the victim:
      // fewest uses, then earliest stamp, then lowest index.
      function int pick_slot();
         int unsigned limit;
         int          best;
         bit          found;
         limit = (capacity > CACHE_SLOTS) ? CACHE_SLOTS : capacity;
         best  = 0;
         found = 1'b0;
         if (fill_count < limit)
            for (int i = 0; i < CACHE_SLOTS; i++)
               if (!slot_used[i]) begin
                  fill_count++;
                  return i;
               end
         for (int i = 0; i < CACHE_SLOTS; i++) begin
            if (slot_used[i] && (!found || slot_uses[i] < slot_uses[best] ||
                (slot_uses[i] == slot_uses[best] && slot_stamp[i] < slot_stamp[best]))) begin
               best  = i;
               found = 1'b1;
            end
         end
         return best;
      endfunction

      function void note_request(logic act, logic [KEY_W-1:0] k, logic signed [VALUE_W-1:0] v);
         rsp_type exp_rsp;
         int      idx;
         int      slot;
         idx                = find_key(k);
         exp_rsp.hit        = (idx >= 0);
         exp_rsp.read_value = VALUE_PUT;
         if (act == ACT_GET) begin
            if (idx >= 0) begin
               bump_use(idx);
               exp_rsp.read_value = slot_value[idx];
            end else begin
               exp_rsp.read_value = VALUE_MISS;
            end
         end else if (capacity != '0) begin
            if (idx >= 0) begin
               bump_use(idx);
               slot_value[idx] = v;
            end else begin
               slot             = pick_slot();
               slot_used[slot]  = 1'b1;
               slot_key[slot]   = k;
               slot_value[slot] = v;
               slot_uses[slot]  = USES_ONE;
               slot_stamp[slot] = stamp_count;
               stamp_count      = stamp_count + STAMP_ONE;
            end
         end
         expected_rsp.push_back(exp_rsp);
      endfunction

      function void check_response(logic hit, logic signed [VALUE_W-1:0] read_value);
         rsp_type exp_rsp;
         if (expected_rsp.size() == 0) begin
            $error("response with none expected: hit %0b read_value %0d", hit, read_value);
            errors++;
            return;
         end
         exp_rsp = expected_rsp.pop_front();
         if (hit !== exp_rsp.hit) begin
            $error("hit mismatch: expected %0b, actual %0b", exp_rsp.hit, hit);
            errors++;
         end
         if (read_value !== exp_rsp.read_value) begin
            $error("read_value mismatch: expected %0d, actual %0d",
                   exp_rsp.read_value, read_value);
            errors++;
         end
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset, channels and the block itself.
   // ------------------------------------------------------------------
   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;

   lfu_req_if req_bus ();
   lfu_rsp_if rsp_bus ();

   cache_scoreboard sb = new();

   // Random idling is switched off per phase for back-to-back stretches.
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;
   int rsp_count = 0;
   int quiet_cycles = 0;

   logic signed [KEY_W-1:0] key_pool [POOL_KEYS];

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   lfu_cache_lru_tiebreak #(
      .ENTRIES     (CACHE_SLOTS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus)
   );

   // ------------------------------------------------------------------
   // Request side.
   // ------------------------------------------------------------------

   // One request transfer. Valid is only lowered when a gap is drawn, so a
   // back-to-back item keeps valid high without a low cycle in between.
   task automatic send_item(input logic act, input logic signed [KEY_W-1:0] k,
                            input logic signed [VALUE_W-1:0] v);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.action <= act;
      req_bus.key    <= k;
      req_bus.value  <= v;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_request(act, k, v);
   endtask

   // Mostly keys from a small pool so gets hit and puts evict; the rest are
   // full-range keys that almost always miss.
   task automatic send_random(input int pool_n);
      logic                      act;
      logic signed [KEY_W-1:0]   k;
      logic signed [VALUE_W-1:0] v;
      act = ($urandom_range(0, 1) != 0) ? ACT_PUT : ACT_GET;
      if ($urandom_range(0, 99) < 85)
         k = key_pool[$urandom_range(0, pool_n - 1)];
      else
         k = $urandom;
      case ($urandom_range(0, 9))
         0:       v = VALUE_MIN;
         1:       v = VALUE_MAX;
         2:       v = VALUE_MISS;
         default: v = $urandom;
      endcase
      send_item(act, k, v);
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Capacity changes only with the block idle: all responses back.
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      wait_drained();
      repeat (2) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      sb.set_capacity(cap);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // One random phase at a given capacity. The pool window tracks the
   // capacity so that eviction pressure stays high.
   task automatic run_phase(input logic [CAP_W-1:0] cap, input int n_items, input bit burst);
      int pool_n;
      write_capacity(cap);
      pool_n = (cap == '0 || cap > CACHE_SLOTS) ? POOL_KEYS : cap + 5;
      if (pool_n > POOL_KEYS)
         pool_n = POOL_KEYS;
      req_burst = burst;
      rsp_burst = burst;
      repeat (n_items) send_random(pool_n);
      req_bus.valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------
   initial begin : stimulus
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= CAP_RESET;
      req_bus.valid  <= 1'b0;
      req_bus.action <= ACT_GET;
      req_bus.key    <= KEY_ZERO;
      req_bus.value  <= '0;

      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MAX;
      key_pool[2] = KEY_ZERO;
      key_pool[3] = KEY_ONES;
      for (int i = 4; i < POOL_KEYS; i++)
         key_pool[i] = $urandom;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: capacity two, so eviction and the tie-break show up quickly.
      write_capacity(5'd2);
      send_item(ACT_GET, KEY_MIN,  VALUE_MAX);   // miss on an empty cache
      send_item(ACT_PUT, KEY_MIN,  VALUE_MAX);
      send_item(ACT_PUT, KEY_MAX,  VALUE_MIN);
      send_item(ACT_GET, KEY_MIN,  '0);          // hit, uses go to two
      send_item(ACT_PUT, KEY_ONES, '0);          // evicts the single-use entry
      send_item(ACT_GET, KEY_MAX,  '0);          // gone
      send_item(ACT_GET, KEY_ONES, '0);          // hit, now tied at two uses
      send_item(ACT_PUT, KEY_ZERO, VALUE_MISS);  // tie: older count loses
      send_item(ACT_GET, KEY_MIN,  '0);          // gone
      send_item(ACT_PUT, KEY_ONES, 32'sd5);      // update in place
      send_item(ACT_GET, KEY_ONES, '0);
      req_bus.valid <= 1'b0;

      // Directed: capacity zero, puts are no-ops but still report hit.
      write_capacity(5'd0);
      send_item(ACT_PUT, KEY_MAX,  32'sd7);      // absent, not stored
      send_item(ACT_PUT, KEY_ZERO, 32'sd9);      // present, left unchanged
      send_item(ACT_GET, KEY_ZERO, '0);          // old value still there
      send_item(ACT_GET, KEY_MAX,  '0);
      req_bus.valid <= 1'b0;

      // Random phases: full size, above the slot count, shrinking below the
      // fill level, disabled, and back.
      run_phase(5'd16, 65, 1'b0);
      run_phase(5'd31, 65, 1'b0);
      run_phase(5'd4,  65, 1'b1);
      run_phase(5'd0,  65, 1'b0);
      run_phase(5'd1,  65, 1'b0);
      run_phase(5'd16, 65, 1'b0);
      run_phase(5'd2,  65, 1'b1);
      run_phase(5'd9,  65, 1'b0);
      run_phase(5'd31, 65, 1'b0);
      run_phase(5'd3,  65, 1'b0);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // Response side: random ready gaps, plus one long hold-off so the
   // output register and the scan both fill and the request side stalls.
   // ------------------------------------------------------------------
   initial begin : rsp_sink
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_count == HOLD_AT_RSP)
            gap = HOLD_CYCLES;
         else
            gap = rsp_burst ? 0 : $urandom_range(0, 17);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         sb.check_response(rsp_bus.hit, rsp_bus.read_value);
         rsp_count++;
      end
   end

   // Hang detector: any transfer on either channel resets the count.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

[sim.f]
rtl/lfu_pkg.sv
rtl/lfu_req_if.sv
rtl/lfu_rsp_if.sv
rtl/lfu_ram.sv
rtl/lfu_scan.sv
rtl/lfu_cache_lru_tiebreak.sv
dv/lfu_cache_lru_tiebreak_tb.sv
